// ===== hdl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the frame allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CFA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CFA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/cfa_pkg.sv =====
// Types and constants shared by the frame allocator controller and datapath.
package cfa_pkg;

    localparam int LEN_W   = 9;   // page count and stored run length
    localparam int FM_W    = 9;   // frames_managed register
    localparam int BASE_W  = 20;  // base_frame register
    localparam int FRAME_W = 21;  // result frame number
    localparam int FREE_W  = 9;   // result free frame count
    localparam int IDX_W   = 8;   // release index

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_NOTUSED = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_CLEAR,
        DP_LATCH,
        DP_INIT_SCAN,
        DP_SCAN,
        DP_MARK,
        DP_INIT_FREE,
        DP_INIT_WALK,
        DP_WALK,
        DP_LOAD
    } dp_op_t;

    typedef struct packed {
        dp_op_t  op;
        status_t res_status;
    } cmd_t;

    typedef struct packed {
        logic is_free;
        logic count_ok;
        logic idx_ok;
        logic clear_done;
        logic scan_hit;
        logic scan_end;
        logic rem_zero;
        logic rd_used;
        logic walk_end;
        logic out_busy;
    } sts_t;

endpackage

// ===== hdl/contiguous_frame_allocator.sv =====
// Contiguous frame allocator: first-fit allocation and release of page frame runs.
//
// Requests enter on the s_ stream (s_tuser = operation, s_tdata = page count and
// release index); one result beat leaves on the m_ stream for every request.
// Registers on the APB port: frames_managed at 0x0, base_frame at 0x4.
// After reset the frame map is swept clear, one entry a cycle; s_tready stays
// low while that pass runs, register writes are taken.
// One request is in work at a time. An allocate reads L map entries in its
// first-fit scan (one per cycle through the single map read port, at most the
// managed limit) and then marks the N requested pages; a failed allocate ends
// after the scan, or before it when the page count is zero or above the limit.
// A free walks the map for R entries, R being the stored run length.
// The result is held in an output register: while the receiver stalls, the
// block still takes one further request and works it up to its result, then
// waits until the held beat is taken.
module contiguous_frame_allocator
#(
    parameter int NUM_FRAMES = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [8:0] page_count, [16:9] release_index
    input  logic        s_tuser,   // [0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [1:0] status, [22:2] frame_number, [31:23] free_frames
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

`include "assert_macros.svh"

    localparam logic REG_FRAMES_MANAGED = 1'b0;
    localparam logic REG_BASE_FRAME     = 1'b1;

    logic [cfa_pkg::FM_W-1:0]    fm_reg;
    logic [cfa_pkg::BASE_W-1:0]  base_reg;
    logic                        cfg_we;

    cfa_pkg::cmd_t               cmd;
    cfa_pkg::sts_t               sts;
    logic                        out_valid;
    cfa_pkg::status_t            out_status;
    logic [cfa_pkg::FRAME_W-1:0] out_frame;
    logic [cfa_pkg::FREE_W-1:0]  out_free;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fm_reg   <= cfa_pkg::FM_W'(256);
            base_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (paddr[2] == REG_FRAMES_MANAGED)
                fm_reg <= pwdata[cfa_pkg::FM_W-1:0];
            else
                base_reg <= pwdata[cfa_pkg::BASE_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_BASE_FRAME) ? 32'(base_reg) : 32'(fm_reg);

    cfa_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cfa_dp #(
        .NUM_FRAMES (NUM_FRAMES)
    ) u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .in_op          (s_tuser),
        .in_count       (s_tdata[8:0]),
        .in_idx         (s_tdata[16:9]),
        .frames_managed (fm_reg),
        .base_frame     (base_reg),
        .out_ready      (m_tready),
        .out_valid      (out_valid),
        .out_status     (out_status),
        .out_frame      (out_frame),
        .out_free       (out_free)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = {out_free, out_frame, out_status};

    // a failed request never carries a frame number
    `CFA_ASSERT_NOW(a_fail_no_frame, out_valid && (out_status != cfa_pkg::ST_OK), out_frame == '0, "failed result carries a frame number")
    // free count never exceeds the managed frames
    `CFA_ASSERT_NOW(a_free_bound, out_valid, out_free <= fm_reg, "free_frames above frames_managed")
    // a result beat only appears after the controller loads it
    `CFA_ASSERT_NOW(a_load_origin, $rose(out_valid), $past(cmd.op == cfa_pkg::DP_LOAD), "result beat without a load")
    // no new request is taken while the map clearing or a request is in work
    `CFA_ASSERT_NEXT(a_accept_idle, s_tvalid && s_tready, !s_tready, "second request taken while busy")

endmodule

// ===== hdl/cfa_ctrl.sv =====
// Sequencing state machine of the frame allocator.
module cfa_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  cfa_pkg::sts_t sts,
    output cfa_pkg::cmd_t cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_MARK,
        S_FREE_RD,
        S_FREE_CHK,
        S_WALK,
        S_FINISH
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    cfa_pkg::status_t  st_reg;
    cfa_pkg::status_t  st_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        st_next        = st_reg;
        cmd.op         = cfa_pkg::DP_NONE;
        cmd.res_status = st_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.op = cfa_pkg::DP_CLEAR;
                if (sts.clear_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = cfa_pkg::DP_LATCH;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.is_free)
                begin
                    if (!sts.idx_ok)
                    begin
                        st_next    = cfa_pkg::ST_NOTUSED;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        cmd.op     = cfa_pkg::DP_INIT_FREE;
                        state_next = S_FREE_RD;
                    end
                end
                else if (!sts.count_ok)
                begin
                    st_next    = cfa_pkg::ST_NOSPACE;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.op     = cfa_pkg::DP_INIT_SCAN;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.op = cfa_pkg::DP_SCAN;
                if (sts.scan_hit)
                    state_next = S_MARK;
                else if (sts.scan_end)
                begin
                    st_next    = cfa_pkg::ST_NOSPACE;
                    state_next = S_FINISH;
                end
            end
            S_MARK:
            begin
                cmd.op = cfa_pkg::DP_MARK;
                if (sts.rem_zero)
                begin
                    st_next    = cfa_pkg::ST_OK;
                    state_next = S_FINISH;
                end
            end
            S_FREE_RD:
            begin
                state_next = S_FREE_CHK;
            end
            S_FREE_CHK:
            begin
                if (!sts.rd_used)
                begin
                    st_next    = cfa_pkg::ST_NOTUSED;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.op     = cfa_pkg::DP_INIT_WALK;
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                cmd.op = cfa_pkg::DP_WALK;
                if (sts.walk_end)
                begin
                    st_next    = cfa_pkg::ST_OK;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                // hold the finished result until the output slot is free
                if (!sts.out_busy)
                begin
                    cmd.op     = cfa_pkg::DP_LOAD;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            st_reg    <= cfa_pkg::ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            st_reg    <= st_next;
        end
    end

endmodule

// ===== hdl/cfa_dp.sv =====
// Datapath of the frame allocator: frame map memory, counters and result register.
module cfa_dp
#(
    parameter int NUM_FRAMES = 256
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  cfa_pkg::cmd_t                 cmd,
    output cfa_pkg::sts_t                 sts,
    input  logic                          in_op,
    input  logic [cfa_pkg::LEN_W-1:0]     in_count,
    input  logic [cfa_pkg::IDX_W-1:0]     in_idx,
    input  logic [cfa_pkg::FM_W-1:0]      frames_managed,
    input  logic [cfa_pkg::BASE_W-1:0]    base_frame,
    input  logic                          out_ready,
    output logic                          out_valid,
    output cfa_pkg::status_t              out_status,
    output logic [cfa_pkg::FRAME_W-1:0]   out_frame,
    output logic [cfa_pkg::FREE_W-1:0]    out_free
);

    localparam int IW  = $clog2(NUM_FRAMES);
    localparam int CW  = $clog2(NUM_FRAMES + 1);
    localparam int XW  = ((CW > cfa_pkg::LEN_W) ? CW : cfa_pkg::LEN_W) + 1;
    localparam int SW  = ((IW > cfa_pkg::LEN_W) ? IW : cfa_pkg::LEN_W) + 1;
    localparam logic [CW-1:0] NUM_C = CW'(NUM_FRAMES);

    typedef struct packed {
        logic                      used;
        logic [cfa_pkg::LEN_W-1:0] len;
    } entry_t;

    entry_t mem [NUM_FRAMES];

    entry_t                      rdata_reg;
    logic [IW-1:0]               probe_reg;
    logic [CW-1:0]               addr_reg;
    logic                        pv_reg;
    logic [CW-1:0]               used_reg;
    logic                        op_reg;
    logic [cfa_pkg::LEN_W-1:0]   count_reg;
    logic [cfa_pkg::IDX_W-1:0]   idx_reg;
    logic [cfa_pkg::LEN_W-1:0]   rem_reg;
    logic [cfa_pkg::LEN_W-1:0]   run_reg;
    logic [IW-1:0]               start_reg;
    logic                        out_valid_reg;
    cfa_pkg::status_t            status_reg;
    logic [cfa_pkg::FRAME_W-1:0] frame_reg;
    logic [cfa_pkg::FREE_W-1:0]  free_reg;

    logic [XW-1:0]               lim_x;
    logic [CW-1:0]               lim;
    logic                        scan_issue;
    logic                        walk_issue;
    logic [cfa_pkg::LEN_W:0]     run_inc;
    logic                        scan_hit;
    logic [SW-1:0]               start_wide;
    logic [IW-1:0]               start_calc;
    logic                        we;
    logic [IW-1:0]               wa;
    entry_t                      wd;
    logic                        alloc_ok;

    // managed limit is min(frames_managed, NUM_FRAMES)
    assign lim_x = (XW'(frames_managed) < XW'(NUM_FRAMES)) ? XW'(frames_managed)
                                                           : XW'(NUM_FRAMES);
    assign lim   = CW'(lim_x);

    assign scan_issue = (addr_reg < lim);
    assign walk_issue = (rem_reg != '0) && (addr_reg < NUM_C);
    assign run_inc    = {1'b0, run_reg} + 1'b1;
    assign scan_hit   = pv_reg && !rdata_reg.used && (run_inc == {1'b0, count_reg});
    assign start_wide = SW'(probe_reg) + SW'(1) - SW'(count_reg);
    assign start_calc = start_wide[IW-1:0];

    always_comb
    begin
        sts.is_free    = (op_reg == cfa_pkg::OP_FREE);
        sts.count_ok   = (count_reg != '0) && (XW'(count_reg) <= lim_x);
        sts.idx_ok     = (XW'(idx_reg) < XW'(NUM_FRAMES));
        sts.clear_done = (addr_reg == NUM_C);
        sts.scan_hit   = scan_hit;
        sts.scan_end   = !pv_reg && !scan_issue;
        sts.rem_zero   = (rem_reg == '0);
        sts.rd_used    = rdata_reg.used;
        sts.walk_end   = !pv_reg && !walk_issue;
        sts.out_busy   = out_valid_reg && !out_ready;
    end

    // map write port
    always_comb
    begin
        we = 1'b0;
        wa = addr_reg[IW-1:0];
        wd = '{used: 1'b0, len: rdata_reg.len};
        unique case (cmd.op)
            cfa_pkg::DP_CLEAR:
            begin
                we = (addr_reg < NUM_C);
            end
            cfa_pkg::DP_MARK:
            begin
                we = (rem_reg != '0);
                wd = '{used: 1'b1, len: count_reg};
            end
            cfa_pkg::DP_WALK:
            begin
                // write back, as free, the frame whose entry the read register holds
                we = pv_reg;
                wa = probe_reg;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        rdata_reg <= mem[addr_reg[IW-1:0]];
        probe_reg <= addr_reg[IW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg      <= '0;
            pv_reg        <= 1'b0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.op == cfa_pkg::DP_LOAD)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            unique case (cmd.op)
                cfa_pkg::DP_CLEAR:
                begin
                    if (addr_reg < NUM_C)
                        addr_reg <= addr_reg + 1'b1;
                end
                cfa_pkg::DP_INIT_SCAN:
                begin
                    addr_reg <= '0;
                    pv_reg   <= 1'b0;
                end
                cfa_pkg::DP_SCAN:
                begin
                    if (scan_hit)
                    begin
                        addr_reg <= CW'(start_calc);
                        pv_reg   <= 1'b0;
                        used_reg <= used_reg + CW'(count_reg);
                    end
                    else
                    begin
                        pv_reg <= scan_issue;
                        if (scan_issue)
                            addr_reg <= addr_reg + 1'b1;
                    end
                end
                cfa_pkg::DP_MARK:
                begin
                    if (rem_reg != '0)
                        addr_reg <= addr_reg + 1'b1;
                end
                cfa_pkg::DP_INIT_FREE:
                begin
                    addr_reg <= CW'(idx_reg);
                    pv_reg   <= 1'b0;
                end
                cfa_pkg::DP_INIT_WALK:
                begin
                    pv_reg <= 1'b0;
                end
                cfa_pkg::DP_WALK:
                begin
                    pv_reg <= walk_issue;
                    if (walk_issue)
                        addr_reg <= addr_reg + 1'b1;
                    // frames already free inside the span are not counted
                    if (pv_reg && rdata_reg.used && (used_reg != '0))
                        used_reg <= used_reg - 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign alloc_ok = (cmd.res_status == cfa_pkg::ST_OK) && (op_reg == cfa_pkg::OP_ALLOC);

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            cfa_pkg::DP_LATCH:
            begin
                op_reg    <= in_op;
                count_reg <= in_count;
                idx_reg   <= in_idx;
            end
            cfa_pkg::DP_INIT_SCAN:
            begin
                run_reg <= '0;
            end
            cfa_pkg::DP_SCAN:
            begin
                if (pv_reg)
                    run_reg <= rdata_reg.used ? '0 : run_inc[cfa_pkg::LEN_W-1:0];
                if (scan_hit)
                begin
                    start_reg <= start_calc;
                    rem_reg   <= count_reg;
                end
            end
            cfa_pkg::DP_MARK:
            begin
                if (rem_reg != '0)
                    rem_reg <= rem_reg - 1'b1;
            end
            cfa_pkg::DP_INIT_WALK:
            begin
                rem_reg <= rdata_reg.len;
            end
            cfa_pkg::DP_WALK:
            begin
                if (walk_issue)
                    rem_reg <= rem_reg - 1'b1;
            end
            cfa_pkg::DP_LOAD:
            begin
                status_reg <= cmd.res_status;
                frame_reg  <= alloc_ok ? (cfa_pkg::FRAME_W'(base_frame)
                                          + cfa_pkg::FRAME_W'(start_reg)) : '0;
                free_reg   <= (lim > used_reg) ? cfa_pkg::FREE_W'(lim - used_reg) : '0;
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign out_status = status_reg;
    assign out_frame  = frame_reg;
    assign out_free   = free_reg;

endmodule
